/* rtl/jtfs_pkg.sv */
// Package with the types, constants and codes shared by the field scanner files.
`timescale 1ns / 1ps

package jtfs_pkg;

    // Offsets and counts are 25 bits wide and saturate at 2^24.
    localparam int OFF_W = 25;
    localparam logic [OFF_W-1:0] MAX_TEXT_BYTES = 25'h100_0000;

    // Bracket depth saturates at this value.
    localparam int DEPTH_W = 8;
    localparam logic [DEPTH_W-1:0] MAX_NEST_DEPTH = 8'd255;

    // Byte order mark.
    localparam logic [7:0] BOM_0 = 8'hEF;
    localparam logic [7:0] BOM_1 = 8'hBB;
    localparam logic [7:0] BOM_2 = 8'hBF;

    // Characters that steer the scan.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Result kinds.
    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Scanner phases.
    typedef enum logic [3:0] {
        PH_MARK0 = 4'd0,
        PH_MARK1 = 4'd1,
        PH_MARK2 = 4'd2,
        PH_LEAD  = 4'd3,
        PH_TOP   = 4'd4,
        PH_KEY   = 4'd5,
        PH_COLON = 4'd6,
        PH_VWS   = 4'd7,
        PH_VSTR  = 4'd8,
        PH_VNEST = 4'd9,
        PH_VBARE = 4'd10,
        PH_DONE  = 4'd11
    } t_phase;

    // Value type codes.
    typedef enum logic [1:0] {
        VT_STRING = 2'd0,
        VT_NEST   = 2'd1,
        VT_BARE   = 2'd2
    } t_vtype;

    // One result transaction.
    typedef struct packed {
        logic             kind;
        logic [OFF_W-1:0] key_start;
        logic [OFF_W-1:0] key_end;
        logic [OFF_W-1:0] value_start;
        logic [OFF_W-1:0] value_end;
        t_vtype           value_type;
        logic [OFF_W-1:0] field_count;
        logic             object_found;
        logic             last_result;
    } t_result;

    // Results that the byte under work produces, first in order in res0.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_scan_out;

endpackage

/* rtl/json_top_level_field_scanner.sv */
// Top level of the JSON top-level field scanner: input register, scanner and result queue.
`timescale 1ns / 1ps

// Scans a JSON text at one byte per clock unless o_stall holds it, and reports
// each key/value pair of the outermost object as byte offsets with its value
// type, then one summary transaction on the byte marked last, after which it
// is ready for a new text. A byte is accepted every cycle that o_stall is low;
// it passes through the input register and the scanner into the result queue,
// from which its first result is offered. The rate is set by the single
// registered pass of the per-byte update and by the two-entry result queue,
// which drains one transaction per cycle while i_stall is low: a last byte that
// closes a field yields two transactions, so the queue stays one entry fuller
// until a cycle pushes nothing, and a later byte that again yields two before
// then is stalled. There is no clearing pass after reset.
module json_top_level_field_scanner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [jtfs_pkg::OFF_W-1:0]    o_key_start,
    output logic [jtfs_pkg::OFF_W-1:0]    o_key_end,
    output logic [jtfs_pkg::OFF_W-1:0]    o_value_start,
    output logic [jtfs_pkg::OFF_W-1:0]    o_value_end,
    output logic [1:0]                    o_value_type,
    output logic [jtfs_pkg::OFF_W-1:0]    o_field_count,
    output logic                          o_object_found,
    output logic                          o_last_result
);
    import jtfs_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       in_take, advance;
    logic [1:0] q_free, push_n;
    t_scan_out  scan;
    t_result    head;

    // Input register: refilled whenever its byte moves into the scanner.
    assign advance    = r_in_valid && (scan.count <= q_free);
    assign o_stall    = r_in_valid && !advance;
    assign in_take    = i_valid && !o_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);
    assign push_n     = advance ? scan.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    jtfs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_data_byte (r_in_byte),
        .i_last      (r_in_last),
        .o_scan      (scan)
    );

    jtfs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (scan.res0),
        .i_res1   (scan.res1),
        .i_stall  (i_stall),
        .o_free   (q_free),
        .o_valid  (o_valid),
        .o_head   (head)
    );

    // Result transaction fields.
    assign o_kind         = head.kind;
    assign o_key_start    = head.key_start;
    assign o_key_end      = head.key_end;
    assign o_value_start  = head.value_start;
    assign o_value_end    = head.value_end;
    assign o_value_type   = head.value_type;
    assign o_field_count  = head.field_count;
    assign o_object_found = head.object_found;
    assign o_last_result  = head.last_result;

`ifndef NO_ASSERTIONS
    // Every last byte that enters the scanner produces its summary.
    a_last_gives_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |-> push_n != 2'd0)
        else $error("last byte produced no summary transaction");

    // Two results for one byte only happen on the last byte.
    a_two_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && scan.count == 2'd2 |-> r_in_last)
        else $error("two results for a byte that is not last");

    // The queue never accepts more than it has room for.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n <= q_free)
        else $error("result queue overflow");

    // A queued result that was not taken is still offered in the next cycle.
    a_head_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");
`endif

endmodule

/* rtl/jtfs_scan.sv */
// Per-byte scanner: parse state registers and the single-pass next-state logic.
`timescale 1ns / 1ps

module jtfs_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    output jtfs_pkg::t_scan_out o_scan
);
    import jtfs_pkg::*;

    t_phase             r_phase, n_phase;
    logic [OFF_W-1:0]   r_pos;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_in_str, n_in_str;
    logic               r_esc, n_esc;
    logic [OFF_W-1:0]   r_ks, n_ks;
    logic [OFF_W-1:0]   r_ke, n_ke;
    logic [OFF_W-1:0]   r_vs, n_vs;
    t_vtype             r_vt, n_vt;
    logic [OFF_W-1:0]   r_fields, n_fields;
    logic               r_obj, n_obj;

    logic [7:0]         b;
    logic               ws;
    logic [OFF_W-1:0]   cur, nxt, fields_inc;
    logic [DEPTH_W-1:0] depth_dec;
    t_phase             p1;
    logic               loop_put;
    logic [OFF_W-1:0]   loop_ve;
    logic               fin_open, fin_noval, field_valid;
    t_result            field_res, summary_res;

    // Position and counter helpers; both saturate at the text limit.
    assign b          = i_data_byte;
    assign ws         = (b <= CH_SPACE);
    assign cur        = r_pos;
    assign nxt        = (r_pos == MAX_TEXT_BYTES) ? MAX_TEXT_BYTES : r_pos + 1'b1;
    assign fields_inc = (r_fields == MAX_TEXT_BYTES) ? MAX_TEXT_BYTES : r_fields + 1'b1;
    assign depth_dec  = (r_depth != '0) ? r_depth - 1'b1 : '0;

    // Phase that actually handles the byte: a missing mark falls through to the
    // leading whitespace check, and a missing colon falls through to the value.
    always_comb begin
        p1 = r_phase;
        if (r_phase == PH_MARK0 && b != BOM_0) begin
            p1 = PH_LEAD;
        end else if (r_phase == PH_COLON && !ws && b != CH_COLON) begin
            p1 = PH_VWS;
        end
    end

    // Next state for one byte, before the end-of-text handling.
    always_comb begin
        n_phase  = p1;
        n_depth  = r_depth;
        n_in_str = r_in_str;
        n_esc    = r_esc;
        n_ks     = r_ks;
        n_ke     = r_ke;
        n_vs     = r_vs;
        n_vt     = r_vt;
        n_obj    = r_obj;
        loop_put = 1'b0;
        loop_ve  = cur;
        unique case (p1)
            PH_MARK0: begin
                n_phase = PH_MARK1;
            end
            PH_MARK1: begin
                n_phase = (b == BOM_1) ? PH_MARK2 : PH_DONE;
            end
            PH_MARK2: begin
                n_phase = (b == BOM_2) ? PH_LEAD : PH_DONE;
            end
            PH_LEAD: begin
                if (!ws) begin
                    if (b == CH_LBRACE) begin
                        n_obj   = 1'b1;
                        n_phase = PH_TOP;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_TOP: begin
                if (b == CH_RBRACE) begin
                    n_phase = PH_DONE;
                end else if (b == CH_QUOTE) begin
                    n_ks    = nxt;
                    n_esc   = 1'b0;
                    n_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (b == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (b == CH_QUOTE) begin
                    n_ke    = cur;
                    n_phase = PH_COLON;
                end
            end
            PH_COLON: begin
                if (!ws) begin
                    n_phase = PH_VWS;
                end
            end
            PH_VWS: begin
                if (!ws) begin
                    n_vs     = cur;
                    n_esc    = 1'b0;
                    n_in_str = 1'b0;
                    if (b == CH_QUOTE) begin
                        n_vt    = VT_STRING;
                        n_phase = PH_VSTR;
                    end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                        n_vt    = VT_NEST;
                        n_depth = DEPTH_W'(1);
                        n_phase = PH_VNEST;
                    end else if (b == CH_COMMA || b == CH_RBRACE) begin
                        // Empty value: close it here, then the byte acts at top level.
                        n_vt     = VT_BARE;
                        loop_put = 1'b1;
                        loop_ve  = cur;
                        n_phase  = (b == CH_RBRACE) ? PH_DONE : PH_TOP;
                    end else begin
                        n_vt    = VT_BARE;
                        n_phase = PH_VBARE;
                    end
                end
            end
            PH_VSTR: begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (b == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (b == CH_QUOTE) begin
                    loop_put = 1'b1;
                    loop_ve  = nxt;
                    n_phase  = PH_TOP;
                end
            end
            PH_VNEST: begin
                if (r_in_str) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (b == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        n_in_str = 1'b0;
                    end
                end else if (b == CH_QUOTE) begin
                    n_in_str = 1'b1;
                end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                    if (r_depth < MAX_NEST_DEPTH) begin
                        n_depth = r_depth + 1'b1;
                    end
                end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                    n_depth = depth_dec;
                    if (depth_dec == '0) begin
                        loop_put = 1'b1;
                        loop_ve  = nxt;
                        n_phase  = PH_TOP;
                    end
                end
            end
            PH_VBARE: begin
                if (b == CH_COMMA || b == CH_RBRACE || b == CH_LF || b == CH_CR) begin
                    // The terminator is then handled at top level.
                    loop_put = 1'b1;
                    loop_ve  = cur;
                    n_phase  = (b == CH_RBRACE) ? PH_DONE : PH_TOP;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // End of text: a field still open is closed at the input length.
    assign fin_open    = i_last && (n_phase >= PH_KEY) && (n_phase <= PH_VBARE);
    assign fin_noval   = (n_phase == PH_KEY) || (n_phase == PH_COLON) || (n_phase == PH_VWS);
    assign field_valid = loop_put || fin_open;
    assign n_fields    = field_valid ? fields_inc : r_fields;

    // Build the field and summary transactions.
    always_comb begin
        field_res              = '0;
        field_res.kind         = KIND_FIELD;
        field_res.key_start    = n_ks;
        field_res.key_end      = (fin_open && n_phase == PH_KEY) ? nxt : n_ke;
        field_res.value_start  = (fin_open && fin_noval) ? nxt : n_vs;
        field_res.value_type   = (fin_open && fin_noval) ? VT_BARE : n_vt;
        field_res.value_end    = loop_put ? loop_ve : nxt;
        field_res.field_count  = fields_inc;
        field_res.object_found = n_obj;
        field_res.last_result  = !i_last;

        summary_res              = '0;
        summary_res.kind         = KIND_SUMMARY;
        summary_res.value_type   = VT_STRING;
        summary_res.field_count  = n_fields;
        summary_res.object_found = n_obj;
        summary_res.last_result  = 1'b1;
    end

    assign o_scan.count = {1'b0, field_valid} + {1'b0, i_last};
    assign o_scan.res0  = field_valid ? field_res : summary_res;
    assign o_scan.res1  = summary_res;

    // State registers; the last byte returns the scanner to its reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase  <= PH_MARK0;
            r_pos    <= '0;
            r_depth  <= '0;
            r_in_str <= 1'b0;
            r_esc    <= 1'b0;
            r_ks     <= '0;
            r_ke     <= '0;
            r_vs     <= '0;
            r_vt     <= VT_STRING;
            r_fields <= '0;
            r_obj    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= nxt;
            r_depth  <= n_depth;
            r_in_str <= n_in_str;
            r_esc    <= n_esc;
            r_ks     <= n_ks;
            r_ke     <= n_ke;
            r_vs     <= n_vs;
            r_vt     <= n_vt;
            r_fields <= n_fields;
            r_obj    <= n_obj;
        end
    end

endmodule

/* rtl/jtfs_outq.sv */
// Two-entry result queue that decouples the scanner from a stalling receiver.
`timescale 1ns / 1ps

module jtfs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  jtfs_pkg::t_result i_res0,
    input  jtfs_pkg::t_result i_res1,
    input  logic              i_stall,
    output logic [1:0]        o_free,
    output logic              o_valid,
    output jtfs_pkg::t_result o_head
);
    import jtfs_pkg::*;

    t_result    r_q0, n_q0;
    t_result    r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;
    assign pop     = o_valid && !i_stall;

    // Space after this cycle's pop.
    always_comb begin
        case (r_cnt)
            2'd0:    o_free = 2'd2;
            2'd1:    o_free = pop ? 2'd2 : 2'd1;
            default: o_free = pop ? 2'd1 : 2'd0;
        endcase
    end

    // Pop shifts the second entry forward, then new results append in order.
    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 1'b1;
        end
        if (i_push_n != 2'd0) begin
            if (n_cnt == 2'd0) begin
                n_q0 = i_res0;
                n_q1 = i_res1;
            end else begin
                n_q1 = i_res0;
            end
            n_cnt = n_cnt + i_push_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

/* tb/jtfs_field_checker.sv */
// Checker for the field scanner: predicts the result transactions of each accepted byte and compares them.
`timescale 1ns / 1ps

module jtfs_field_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_kind,
    input  logic [jtfs_pkg::OFF_W-1:0]    i_key_start,
    input  logic [jtfs_pkg::OFF_W-1:0]    i_key_end,
    input  logic [jtfs_pkg::OFF_W-1:0]    i_value_start,
    input  logic [jtfs_pkg::OFF_W-1:0]    i_value_end,
    input  logic [1:0]                    i_value_type,
    input  logic [jtfs_pkg::OFF_W-1:0]    i_field_count,
    input  logic                          i_object_found,
    input  logic                          i_last_result,
    output int                            o_fail_count,
    output int                            o_pending
);

    import jtfs_pkg::*;

    // Scanner state as this checker tracks it.
    t_phase            scan_phase;
    logic [OFF_W-1:0]  byte_pos;
    logic [DEPTH_W-1:0] bracket_depth;
    logic              in_string;
    logic              escape_open;
    logic [OFF_W-1:0]  key_start_q;
    logic [OFF_W-1:0]  key_end_q;
    logic [OFF_W-1:0]  value_start_q;
    t_vtype            value_type_q;
    logic [OFF_W-1:0]  fields_found;
    logic              brace_seen;

    // Field and summary transactions still owed by the scanner, oldest first.
    t_result expected_results[$];
    int      fail_total = 0;

    // Back to the state of a scanner waiting for a new text.
    task clear_scan();
        scan_phase = PH_MARK0;
        byte_pos = '0;
        bracket_depth = '0;
        in_string = 1'b0;
        escape_open = 1'b0;
        key_start_q = '0;
        key_end_q = '0;
        value_start_q = '0;
        value_type_q = VT_STRING;
        fields_found = '0;
        brace_seen = 1'b0;
    endtask

    task record_result(input logic kind, input logic [OFF_W-1:0] ks,
                       input logic [OFF_W-1:0] ke, input logic [OFF_W-1:0] vs,
                       input logic [OFF_W-1:0] ve, input t_vtype vt);
        t_result r;
        r.kind = kind;
        r.key_start = ks;
        r.key_end = ke;
        r.value_start = vs;
        r.value_end = ve;
        r.value_type = vt;
        r.field_count = fields_found;
        r.object_found = brace_seen;
        r.last_result = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endtask

    // A closed field bumps the saturating count before it is reported.
    task record_field(input logic [OFF_W-1:0] vend);
        if (fields_found < MAX_TEXT_BYTES)
            fields_found = fields_found + 1'b1;
        record_result(KIND_FIELD, key_start_q, key_end_q, value_start_q, vend,
                      value_type_q);
    endtask

    // Advances the scanner by one byte and queues the transactions it causes.
    task scan_byte(input logic [7:0] b, input logic fin);
        logic [OFF_W-1:0] cur;
        logic [OFF_W-1:0] nxt;
        logic             blank;
        logic             again;
        int               first_new;
        cur = byte_pos;
        nxt = (cur >= MAX_TEXT_BYTES) ? MAX_TEXT_BYTES : cur + 1'b1;
        blank = (b <= CH_SPACE);
        first_new = expected_results.size();
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (scan_phase)
                PH_MARK0: begin
                    if (b == BOM_0) begin
                        scan_phase = PH_MARK1;
                    end else begin
                        scan_phase = PH_LEAD;
                        again = 1'b1;
                    end
                end
                PH_MARK1: scan_phase = (b == BOM_1) ? PH_MARK2 : PH_DONE;
                PH_MARK2: scan_phase = (b == BOM_2) ? PH_LEAD : PH_DONE;
                PH_LEAD: begin
                    if (!blank) begin
                        if (b == CH_LBRACE) begin
                            brace_seen = 1'b1;
                            scan_phase = PH_TOP;
                        end else begin
                            scan_phase = PH_DONE;
                        end
                    end
                end
                PH_TOP: begin
                    if (b == CH_RBRACE) begin
                        scan_phase = PH_DONE;
                    end else if (b == CH_QUOTE) begin
                        key_start_q = nxt;
                        escape_open = 1'b0;
                        scan_phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (escape_open) begin
                        escape_open = 1'b0;
                    end else if (b == CH_BSLASH) begin
                        escape_open = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        key_end_q = cur;
                        scan_phase = PH_COLON;
                    end
                end
                PH_COLON: begin
                    // A missing colon lets this byte start the value.
                    if (!blank) begin
                        scan_phase = PH_VWS;
                        if (b != CH_COLON)
                            again = 1'b1;
                    end
                end
                PH_VWS: begin
                    if (!blank) begin
                        value_start_q = cur;
                        escape_open = 1'b0;
                        in_string = 1'b0;
                        if (b == CH_QUOTE) begin
                            value_type_q = VT_STRING;
                            scan_phase = PH_VSTR;
                        end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                            value_type_q = VT_NEST;
                            bracket_depth = DEPTH_W'(1);
                            scan_phase = PH_VNEST;
                        end else if (b == CH_COMMA || b == CH_RBRACE) begin
                            // Empty value: closed here, byte handled again at top level.
                            value_type_q = VT_BARE;
                            record_field(cur);
                            scan_phase = PH_TOP;
                            again = 1'b1;
                        end else begin
                            value_type_q = VT_BARE;
                            scan_phase = PH_VBARE;
                        end
                    end
                end
                PH_VSTR: begin
                    if (escape_open) begin
                        escape_open = 1'b0;
                    end else if (b == CH_BSLASH) begin
                        escape_open = 1'b1;
                    end else if (b == CH_QUOTE) begin
                        record_field(nxt);
                        scan_phase = PH_TOP;
                    end
                end
                PH_VNEST: begin
                    if (in_string) begin
                        if (escape_open)
                            escape_open = 1'b0;
                        else if (b == CH_BSLASH)
                            escape_open = 1'b1;
                        else if (b == CH_QUOTE)
                            in_string = 1'b0;
                    end else if (b == CH_QUOTE) begin
                        in_string = 1'b1;
                    end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                        if (bracket_depth < MAX_NEST_DEPTH)
                            bracket_depth = bracket_depth + 1'b1;
                    end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                        if (bracket_depth > 0)
                            bracket_depth = bracket_depth - 1'b1;
                        if (bracket_depth == 0) begin
                            record_field(nxt);
                            scan_phase = PH_TOP;
                        end
                    end
                end
                PH_VBARE: begin
                    if (b == CH_COMMA || b == CH_RBRACE || b == CH_LF || b == CH_CR) begin
                        record_field(cur);
                        scan_phase = PH_TOP;
                        again = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        byte_pos = nxt;

        // On the final byte a pending field is closed at the text length.
        if (fin) begin
            if (scan_phase >= PH_KEY && scan_phase <= PH_VBARE) begin
                if (scan_phase == PH_KEY)
                    key_end_q = nxt;
                if (scan_phase == PH_KEY || scan_phase == PH_COLON || scan_phase == PH_VWS) begin
                    value_start_q = nxt;
                    value_type_q = VT_BARE;
                end
                record_field(nxt);
            end
            record_result(KIND_SUMMARY, '0, '0, '0, '0, VT_STRING);
        end

        // The newest transaction of this byte carries the last-result flag.
        if (expected_results.size() > first_new)
            expected_results[expected_results.size() - 1].last_result = 1'b1;
        if (fin)
            clear_scan();
    endtask

    function string describe(input t_result r);
        return $sformatf({"kind %0d key %0d..%0d value %0d..%0d type %0d count %0d",
                          " obj %0d last %0d"},
                         r.kind, r.key_start, r.key_end, r.value_start, r.value_end,
                         r.value_type, r.field_count, r.object_found, r.last_result);
    endfunction

    task note_mismatch(input string what, input t_result want, input t_result got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
        end
    endtask

    // Predict on each input transaction, then check each result transaction.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_scan();
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                scan_byte(i_data_byte, i_last);
            if (i_out_valid && !i_out_stall) begin
                got.kind = i_kind;
                got.key_start = i_key_start;
                got.key_end = i_key_end;
                got.value_start = i_value_start;
                got.value_end = i_value_end;
                got.value_type = t_vtype'(i_value_type);
                got.field_count = i_field_count;
                got.object_found = i_object_found;
                got.last_result = i_last_result;
                if (expected_results.size() == 0) begin
                    note_mismatch("result transaction with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        note_mismatch("result transaction mismatch", want, got);
                end
            end
        end
        o_pending <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/json_top_level_field_scanner_test.sv */
// Top of the field scanner testbench: clock, reset, byte stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module json_top_level_field_scanner_test;

    import jtfs_pkg::*;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_kind;
    logic [OFF_W-1:0]   o_key_start;
    logic [OFF_W-1:0]   o_key_end;
    logic [OFF_W-1:0]   o_value_start;
    logic [OFF_W-1:0]   o_value_end;
    logic [1:0]         o_value_type;
    logic [OFF_W-1:0]   o_field_count;
    logic               o_object_found;
    logic               o_last_result;

    int                 fail_count;
    int                 results_owed;

    // When set, neither side idles.
    logic               steady = 1'b0;

    // Bytes of the text about to be sent, and how many of them the scanner acts on.
    logic [7:0]         text_bytes[$];
    int                 useful_len;
    int                 bytes_sent = 0;
    logic               deep_sent = 1'b0;

    json_top_level_field_scanner uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_key_start    (o_key_start),
        .o_key_end      (o_key_end),
        .o_value_start  (o_value_start),
        .o_value_end    (o_value_end),
        .o_value_type   (o_value_type),
        .o_field_count  (o_field_count),
        .o_object_found (o_object_found),
        .o_last_result  (o_last_result)
    );

    jtfs_field_checker field_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_kind         (o_kind),
        .i_key_start    (o_key_start),
        .i_key_end      (o_key_end),
        .i_value_start  (o_value_start),
        .i_value_end    (o_value_end),
        .i_value_type   (o_value_type),
        .i_field_count  (o_field_count),
        .i_object_found (o_object_found),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_pending      (results_owed)
    );

    // 50 MHz clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The result side stalls at random outside the steady stretch.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 12);
    end

    // Run limit.
    initial begin
        #4_000_000;
        $display("json_top_level_field_scanner test failed");
        $finish;
    end

    // Appends one byte to the text.
    task put_byte(input logic [7:0] v);
        text_bytes.insert(text_bytes.size(), v);
    endtask

    task add_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task add_blanks();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(4))
                0: put_byte(8'h09);
                1: put_byte(CH_LF);
                2: put_byte(CH_CR);
                3: put_byte(8'($urandom_range(0, 32)));
                default: put_byte(CH_SPACE);
            endcase
        end
    endtask

    // A quoted string with letters, high bytes and escapes of any byte.
    task add_quoted();
        int pick;
        put_byte(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                put_byte(CH_BSLASH);
                put_byte(8'($urandom_range(255)));
            end else if (pick == 1) begin
                put_byte(8'($urandom_range(128, 255)));
            end else begin
                put_byte(8'h61 + 8'($urandom_range(25)));
            end
        end
        put_byte(CH_QUOTE);
    endtask

    task add_scalar();
        string alphabet;
        alphabet = "0123456789-.eE+truefalsn";
        repeat ($urandom_range(1, 4))
            put_byte(alphabet[$urandom_range(alphabet.len() - 1)]);
    endtask

    // A bracketed value with strings inside; closers are picked at random, so
    // brackets are often mismatched.
    task add_nested(input int max_level);
        int level;
        level = 1;
        put_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
        while (level > 0) begin
            case ($urandom_range(7))
                0: begin
                    if (level < max_level) begin
                        put_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
                        level++;
                    end
                end
                1, 2: begin
                    put_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
                    level--;
                end
                3: add_quoted();
                4: add_scalar();
                5: put_byte(CH_COMMA);
                6: put_byte(CH_COLON);
                default: add_blanks();
            endcase
        end
    endtask

    // Mostly well-formed objects with random content; some noise, broken
    // marks, missing braces and texts cut short.
    task compose_text();
        int pick;
        int nfields;
        int cut;
        text_bytes.delete();
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 10))
                put_byte(8'($urandom_range(255)));
            useful_len = 1;
        end else begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                put_byte(BOM_0);
                put_byte(BOM_1);
                put_byte(BOM_2);
            end else if (pick < 23) begin
                put_byte(BOM_0);
                put_byte(8'($urandom_range(255)));
            end else if (pick < 25) begin
                put_byte(BOM_0);
                put_byte(BOM_1);
                put_byte(8'($urandom_range(255)));
            end
            add_blanks();
            if ($urandom_range(15) == 0)
                put_byte(8'($urandom_range(255)));
            else
                put_byte(CH_LBRACE);
            nfields = $urandom_range(0, 5);
            for (int f = 0; f < nfields; f++) begin
                add_blanks();
                if ($urandom_range(9) == 0)
                    put_byte(8'($urandom_range(255)));
                add_quoted();
                add_blanks();
                if ($urandom_range(9) != 0)
                    put_byte(CH_COLON);
                add_blanks();
                pick = $urandom_range(9);
                if (pick < 3)
                    add_quoted();
                else if (pick < 6)
                    add_nested($urandom_range(1, 4));
                else if (pick < 9)
                    add_scalar();
                add_blanks();
                if (f < nfields - 1)
                    put_byte(($urandom_range(7) == 0) ? CH_LF : CH_COMMA);
            end
            add_blanks();
            if ($urandom_range(4) != 0)
                put_byte(CH_RBRACE);
            useful_len = text_bytes.size();
            repeat ($urandom_range(0, 3))
                put_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0) begin
            cut = $urandom_range(1, text_bytes.size());
            while (text_bytes.size() > cut)
                void'(text_bytes.pop_back());
            if (useful_len > cut)
                useful_len = cut;
        end
    endtask

    // Sends the text, marking its final byte; the sender idles at random.
    task send_text();
        for (int i = 0; i < text_bytes.size(); i++) begin
            while (!steady && $urandom_range(99) < 12) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data_byte <= text_bytes[i];
            i_last <= (i == text_bytes.size() - 1);
            @(posedge i_clk);
            while (o_stall)
                @(posedge i_clk);
        end
        bytes_sent += useful_len;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Mark, escaped quote in a key, nested value, empty value, top-level
        // close, then an ignored all-ones byte as the last.
        text_bytes.delete();
        put_byte(BOM_0);
        put_byte(BOM_1);
        put_byte(BOM_2);
        add_chars("{\"a\\\"\":{[]},\"b\",}");
        put_byte(8'hFF);
        useful_len = text_bytes.size();
        send_text();

        // Partial mark.
        text_bytes.delete();
        put_byte(BOM_0);
        put_byte(8'h41);
        useful_len = 2;
        send_text();

        // Zero byte as whitespace, then an escape on the final byte of a key.
        text_bytes.delete();
        put_byte(8'h00);
        add_chars("{\"\\");
        useful_len = 4;
        send_text();

        while (bytes_sent < 1950) begin
            steady <= (bytes_sent >= 1000 && bytes_sent < 1400);
            if (!deep_sent && bytes_sent >= 400) begin
                // Nesting beyond the depth limit, then exactly the limit of closers.
                text_bytes.delete();
                add_chars("{\"d\":");
                repeat (258) put_byte(CH_LBRACK);
                repeat (255) put_byte(CH_RBRACK);
                put_byte(CH_RBRACE);
                useful_len = text_bytes.size();
                deep_sent = 1'b1;
            end else begin
                compose_text();
            end
            send_text();
        end
        i_valid <= 1'b0;
        steady <= 1'b0;

        @(posedge i_clk);
        while (results_owed != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0)
            $display("json_top_level_field_scanner test passed");
        else
            $display("json_top_level_field_scanner test failed");
        $finish;
    end

endmodule
